@@ rtl/core/lvm_pkg.sv @@
package lvm_pkg;

  localparam int WORD_BITS = 32;
  localparam int MAT_ROWS  = 4;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] dir_x;
    logic signed [WORD_BITS-1:0] dir_y;
    logic signed [WORD_BITS-1:0] dir_z;
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] pos_z;
  } lvm_in_t;

  typedef struct packed {
    logic        [1:0]           row_index;
    logic signed [WORD_BITS-1:0] elem_0;
    logic signed [WORD_BITS-1:0] elem_1;
    logic signed [WORD_BITS-1:0] elem_2;
    logic signed [WORD_BITS-1:0] elem_3;
    logic                        degenerate;
    logic                        last_row;
  } lvm_out_t;

endpackage

@@ rtl/core/lvm_norm.sv @@
module lvm_norm #(
  parameter int FRAC_BITS = 16,
  parameter int IN_W      = 33,
  parameter int SIDE_W    = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [2:0][IN_W-1:0]            vec_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            out_valid,
  output logic [2:0][FRAC_BITS+1:0]       unit_o,
  output logic                            degen_o,
  output logic [SIDE_W-1:0]               side_o
);

  localparam int MB      = 30;
  localparam int NW      = 2 * MB + 2;
  localparam int RW      = NW + 1;
  localparam int LW      = MB + 1;
  localparam int SQ_N    = LW;
  localparam int QW      = FRAC_BITS + 1;
  localparam int CW      = FRAC_BITS + 2;
  localparam int NUMW    = MB + FRAC_BITS + 1;
  localparam int PW      = $clog2(IN_W);
  localparam int EW      = IN_W + MB;
  localparam int SW      = $clog2(EW);
  localparam int CARRY_W = SIDE_W + 4 + 3 * MB;
  localparam int DC_W    = SIDE_W + 4;

  // magnitude and range detection
  logic                     s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [2:0][IN_W-1:0]     s1_mag_r, s2_mag_r, s3_mag_r;
  logic [2:0]               s1_neg_r, s2_neg_r, s3_neg_r, s4_neg_r, s5_neg_r;
  logic [SIDE_W-1:0]        s1_side_r, s2_side_r, s3_side_r, s4_side_r, s5_side_r;
  logic [IN_W-1:0]          s2_mx_r;
  logic [PW-1:0]            s3_pos_r;
  logic                     s3_zero_r, s4_zero_r, s5_zero_r;
  logic [2:0][MB-1:0]       s4_m_r, s5_m_r;
  logic [2:0][2*MB-1:0]     s5_sq_r;

  logic [2:0][IN_W-1:0]     s1_mag_nxt;
  logic [IN_W-1:0]          s2_mx_nxt;
  logic [PW-1:0]            s3_pos_nxt;
  logic [2:0][MB-1:0]       s4_m_nxt;

  // square root, one result bit per stage
  logic                     sq_v_r [0:SQ_N];
  logic [NW-1:0]            sq_n_r [0:SQ_N];
  logic [RW-1:0]            sq_r_r [0:SQ_N];
  logic [CARRY_W-1:0]       sq_c_r [0:SQ_N];
  logic [NW-1:0]            sq_n_nxt [1:SQ_N];
  logic [RW-1:0]            sq_r_nxt [1:SQ_N];

  // division, one quotient bit per stage
  logic                     dv_v_r   [0:QW];
  logic [2:0][LW-1:0]       dv_rem_r [0:QW];
  logic [2:0][QW-1:0]       dv_nl_r  [0:QW];
  logic [2:0][QW-1:0]       dv_q_r   [0:QW];
  logic [LW-1:0]            dv_len_r [0:QW];
  logic [DC_W-1:0]          dv_c_r   [0:QW];
  logic [2:0][LW-1:0]       dv_rem_nxt [1:QW];
  logic [2:0][QW-1:0]       dv_q_nxt   [1:QW];
  logic [2:0][LW-1:0]       dv_rem0_nxt;
  logic [2:0][QW-1:0]       dv_nl0_nxt;

  logic                     o_v_r;
  logic [2:0][CW-1:0]       o_unit_r;
  logic                     o_deg_r;
  logic [SIDE_W-1:0]        o_side_r;
  logic [2:0][CW-1:0]       o_unit_nxt;

  logic [2:0][MB-1:0]       sq_m_end;
  logic [2:0]               dv_neg_end;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_mag_nxt[k] = vec_i[k][IN_W-1] ? (IN_W'(0) - vec_i[k]) : vec_i[k];
    end
  end

  always_comb begin
    s2_mx_nxt = s1_mag_r[0];
    if (s1_mag_r[1] > s2_mx_nxt) s2_mx_nxt = s1_mag_r[1];
    if (s1_mag_r[2] > s2_mx_nxt) s2_mx_nxt = s1_mag_r[2];
  end

  always_comb begin
    s3_pos_nxt = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (s2_mx_r[b]) s3_pos_nxt = PW'(b);
    end
  end

  always_comb begin
    logic [SW-1:0] pos_e;
    logic [SW-1:0] amt;
    logic          right;
    logic [EW-1:0] ext;
    pos_e = SW'(s3_pos_r);
    right = pos_e >= SW'(MB - 1);
    amt   = right ? (pos_e - SW'(MB - 1)) : (SW'(MB - 1) - pos_e);
    for (int k = 0; k < 3; k++) begin
      ext = EW'(s3_mag_r[k]);
      ext = right ? (ext >> amt) : (ext << amt);
      s4_m_nxt[k] = ext[MB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mag_r  <= s1_mag_nxt;
    s1_neg_r  <= {vec_i[2][IN_W-1], vec_i[1][IN_W-1], vec_i[0][IN_W-1]};
    s1_side_r <= side_i;
    s2_mx_r   <= s2_mx_nxt;
    s2_mag_r  <= s1_mag_r;
    s2_neg_r  <= s1_neg_r;
    s2_side_r <= s1_side_r;
    s3_pos_r  <= s3_pos_nxt;
    s3_zero_r <= s2_mx_r == '0;
    s3_mag_r  <= s2_mag_r;
    s3_neg_r  <= s2_neg_r;
    s3_side_r <= s2_side_r;
    s4_m_r    <= s4_m_nxt;
    s4_zero_r <= s3_zero_r;
    s4_neg_r  <= s3_neg_r;
    s4_side_r <= s3_side_r;
    for (int k = 0; k < 3; k++) begin
      s5_sq_r[k] <= (2*MB)'(s4_m_r[k]) * (2*MB)'(s4_m_r[k]);
    end
    s5_m_r    <= s4_m_r;
    s5_zero_r <= s4_zero_r;
    s5_neg_r  <= s4_neg_r;
    s5_side_r <= s4_side_r;
  end

  always_comb begin
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    for (int i = 0; i < SQ_N; i++) begin
      bitv  = RW'(1) << (2 * (SQ_N - 1 - i));
      trial = sq_r_r[i] + bitv;
      if (RW'(sq_n_r[i]) >= trial) begin
        sq_n_nxt[i+1] = sq_n_r[i] - trial[NW-1:0];
        sq_r_nxt[i+1] = (sq_r_r[i] >> 1) + bitv;
      end else begin
        sq_n_nxt[i+1] = sq_n_r[i];
        sq_r_nxt[i+1] = sq_r_r[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= SQ_N; i++) sq_v_r[i] <= 1'b0;
    end else begin
      sq_v_r[0] <= s5_v_r;
      for (int i = 1; i <= SQ_N; i++) sq_v_r[i] <= sq_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    sq_n_r[0] <= NW'(s5_sq_r[0]) + NW'(s5_sq_r[1]) + NW'(s5_sq_r[2]);
    sq_r_r[0] <= '0;
    sq_c_r[0] <= {s5_side_r, s5_zero_r, s5_neg_r, s5_m_r};
    for (int i = 1; i <= SQ_N; i++) begin
      sq_n_r[i] <= sq_n_nxt[i];
      sq_r_r[i] <= sq_r_nxt[i];
      sq_c_r[i] <= sq_c_r[i-1];
    end
  end

  assign sq_m_end = sq_c_r[SQ_N][3*MB-1:0];

  always_comb begin
    logic [NUMW-1:0] numer;
    for (int k = 0; k < 3; k++) begin
      numer          = (NUMW'(sq_m_end[k]) << FRAC_BITS)
                     + NUMW'(sq_r_r[SQ_N][LW-1:1]);
      dv_rem0_nxt[k] = LW'(numer >> QW);
      dv_nl0_nxt[k]  = numer[QW-1:0];
    end
  end

  always_comb begin
    logic [LW:0] rem2;
    for (int j = 0; j < QW; j++) begin
      for (int k = 0; k < 3; k++) begin
        rem2 = {dv_rem_r[j][k], dv_nl_r[j][k][QW-1-j]};
        if (rem2 >= {1'b0, dv_len_r[j]}) begin
          dv_rem_nxt[j+1][k] = LW'(rem2 - {1'b0, dv_len_r[j]});
          dv_q_nxt[j+1][k]   = {dv_q_r[j][k][QW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[j+1][k] = rem2[LW-1:0];
          dv_q_nxt[j+1][k]   = {dv_q_r[j][k][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QW; j++) dv_v_r[j] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[SQ_N];
      for (int j = 1; j <= QW; j++) dv_v_r[j] <= dv_v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    dv_rem_r[0] <= dv_rem0_nxt;
    dv_nl_r[0]  <= dv_nl0_nxt;
    dv_q_r[0]   <= '0;
    dv_len_r[0] <= sq_r_r[SQ_N][LW-1:0];
    dv_c_r[0]   <= sq_c_r[SQ_N][CARRY_W-1:3*MB];
    for (int j = 1; j <= QW; j++) begin
      dv_rem_r[j] <= dv_rem_nxt[j];
      dv_nl_r[j]  <= dv_nl_r[j-1];
      dv_q_r[j]   <= dv_q_nxt[j];
      dv_len_r[j] <= dv_len_r[j-1];
      dv_c_r[j]   <= dv_c_r[j-1];
    end
  end

  assign dv_neg_end = dv_c_r[QW][2:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_c_r[QW][3]) begin
        o_unit_nxt[k] = '0;
      end else if (dv_neg_end[k]) begin
        o_unit_nxt[k] = CW'(0) - CW'(dv_q_r[QW][k]);
      end else begin
        o_unit_nxt[k] = CW'(dv_q_r[QW][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    o_unit_r <= o_unit_nxt;
    o_deg_r  <= dv_c_r[QW][3];
    o_side_r <= dv_c_r[QW][DC_W-1:4];
  end

  assign out_valid = o_v_r;
  assign unit_o    = o_unit_r;
  assign degen_o   = o_deg_r;
  assign side_o    = o_side_r;

endmodule

@@ rtl/core/lookat_view_matrix.sv @@
// Channel  Handshake        Payload                     Transaction
// in       start / busy     in_data  (lvm_in_t)         start & !busy at a rising edge
// out      out_valid        out_data (lvm_out_t)        every cycle out_valid is high
//
// A new item can be accepted while earlier items are still in the pipeline; busy
// stays high after each accepted transaction so that the four rows of each item
// leave without overlap. Each item passes through three normalisers in series,
// each with a one-bit-per-stage square root (31 stages) and divider
// (FRAC_BITS + 1 stages). Rows 0 to 3 leave on consecutive cycles. The receiver
// cannot stall; the pipeline never holds.
// rst_n clears all valid bits and the busy counter.
module lookat_view_matrix
  import lvm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lvm_in_t  in_data,
  output logic     out_valid,
  output lvm_out_t out_data
);

  localparam int W      = WORD_BITS;
  localparam int CW     = FRAC_BITS + 2;
  localparam int AW     = W + 1;
  localparam int BW     = CW + 1;
  localparam int PRW    = 2 * CW;
  localparam int XW     = 2 * CW + 1;
  localparam int DPW    = CW + W;
  localparam int DSW    = DPW + 2;
  localparam int DRW    = DSW - FRAC_BITS;
  localparam int SIDE_A = 3 * W;
  localparam int SIDE_B = 3 * W + 3 * CW + 1;
  localparam int SIDE_C = 3 * W + 6 * CW + 1;
  localparam int GW     = $clog2(MAT_ROWS);

  localparam logic [GW-1:0]         GAP      = GW'(MAT_ROWS - 1);
  localparam logic [1:0]            ROW_LAST = 2'(MAT_ROWS - 1);
  localparam logic signed [W-1:0]   ONE_Q    = W'(1) << FRAC_BITS;
  localparam logic signed [DSW-1:0] HALF     = DSW'(1) << (FRAC_BITS - 1);
  localparam logic signed [DRW:0]   T_MAX    =
    {{(DRW + 1 - W){1'b0}}, 1'b0, {(W - 1){1'b1}}};
  localparam logic signed [DRW:0]   T_MIN    =
    {{(DRW + 2 - W){1'b1}}, {(W - 1){1'b0}}};

  logic                    accept;
  logic [GW-1:0]           gap_r;

  logic                    t0_v_r;
  logic [2:0][AW-1:0]      t0_d_r;
  logic [2:0][W-1:0]       t0_p_r;

  logic                    a_v;
  logic [2:0][CW-1:0]      a_f;
  logic                    a_deg;
  logic [SIDE_A-1:0]       a_side;

  logic                    t1_v_r;
  logic [2:0][BW-1:0]      t1_vec_r;
  logic [SIDE_B-1:0]       t1_side_r;

  logic                    b_v;
  logic [2:0][CW-1:0]      b_r;
  logic                    b_deg;
  logic [SIDE_B-1:0]       b_side;
  logic [2:0][CW-1:0]      b_f;

  logic                    t2_v_r;
  logic signed [PRW-1:0]   t2_p_r [0:3];
  logic [SIDE_C-1:0]       t2_side_r;
  logic [2:0][CW-1:0]      t2_f;
  logic [2:0][CW-1:0]      t2_r;

  logic                    t3_v_r;
  logic [2:0][XW-1:0]      t3_vec_r;
  logic [SIDE_C-1:0]       t3_side_r;

  logic                    c_v;
  logic [2:0][CW-1:0]      c_u;
  logic                    c_deg;
  logic [SIDE_C-1:0]       c_side;

  logic [2:0][W-1:0]       c_pos;
  logic [2:0][2:0][CW-1:0] c_ax;

  logic                    d1_v_r;
  logic signed [DPW-1:0]   d1_p_r [0:2][0:2];
  logic [2:0][2:0][CW-1:0] d1_ax_r;
  logic                    d1_deg_r;

  logic                    d2_v_r;
  logic signed [DSW-1:0]   d2_s_r [0:2];
  logic [2:0][2:0][CW-1:0] d2_ax_r;
  logic                    d2_deg_r;

  logic signed [W-1:0]     t_nxt [0:2];

  logic                    ov_r;
  logic [1:0]              row_r;
  logic [2:0][2:0][CW-1:0] ax_r;
  logic signed [W-1:0]     tr_r [0:2];
  logic                    deg_r;

  assign accept = start && !busy;
  assign busy   = gap_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= '0;
      t0_v_r <= 1'b0;
    end else begin
      t0_v_r <= accept;
      if (accept) begin
        gap_r <= GAP;
      end else if (busy) begin
        gap_r <= gap_r - GW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    t0_d_r[0] <= AW'(0) - AW'(in_data.dir_x);
    t0_d_r[1] <= AW'(0) - AW'(in_data.dir_y);
    t0_d_r[2] <= AW'(0) - AW'(in_data.dir_z);
    t0_p_r    <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  end

  lvm_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (AW),
    .SIDE_W    (SIDE_A)
  ) u_norm_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t0_v_r),
    .vec_i     (t0_d_r),
    .side_i    (t0_p_r),
    .out_valid (a_v),
    .unit_o    (a_f),
    .degen_o   (a_deg),
    .side_o    (a_side)
  );

  // right = norm(up0 x forward) = norm(f.z, 0, -f.x)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else begin
      t1_v_r <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    t1_vec_r[0] <= BW'($signed(a_f[2]));
    t1_vec_r[1] <= '0;
    t1_vec_r[2] <= BW'(0) - BW'($signed(a_f[0]));
    t1_side_r   <= {a_side, a_f, a_deg};
  end

  lvm_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (BW),
    .SIDE_W    (SIDE_B)
  ) u_norm_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t1_v_r),
    .vec_i     (t1_vec_r),
    .side_i    (t1_side_r),
    .out_valid (b_v),
    .unit_o    (b_r),
    .degen_o   (b_deg),
    .side_o    (b_side)
  );

  assign b_f = b_side[3*CW:1];

  // right.y is always zero, so the cross product needs four terms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
    end else begin
      t2_v_r <= b_v;
      t3_v_r <= t2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    t2_p_r[0] <= $signed(b_f[1]) * $signed(b_r[2]);
    t2_p_r[1] <= $signed(b_f[2]) * $signed(b_r[0]);
    t2_p_r[2] <= $signed(b_f[0]) * $signed(b_r[2]);
    t2_p_r[3] <= $signed(b_f[1]) * $signed(b_r[0]);
    t2_side_r <= {b_side[SIDE_B-1:3*CW+1], b_f, b_r, b_deg | b_side[0]};
  end

  assign t2_f = t2_side_r[6*CW:3*CW+1];
  assign t2_r = t2_side_r[3*CW:1];

  always_ff @(posedge clk) begin
    t3_vec_r[0] <= XW'(t2_p_r[0]);
    t3_vec_r[1] <= XW'(t2_p_r[1]) - XW'(t2_p_r[2]);
    t3_vec_r[2] <= XW'(0) - XW'(t2_p_r[3]);
    t3_side_r   <= {t2_side_r[SIDE_C-1:6*CW+1], t2_f, t2_r, t2_side_r[0]};
  end

  lvm_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (XW),
    .SIDE_W    (SIDE_C)
  ) u_norm_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t3_v_r),
    .vec_i     (t3_vec_r),
    .side_i    (t3_side_r),
    .out_valid (c_v),
    .unit_o    (c_u),
    .degen_o   (c_deg),
    .side_o    (c_side)
  );

  assign c_pos    = c_side[SIDE_C-1:6*CW+1];
  assign c_ax[0]  = c_side[3*CW:1];
  assign c_ax[1]  = c_u;
  assign c_ax[2]  = c_side[6*CW:3*CW+1];

  // translations: axis . position, rounded half up, negated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
    end else begin
      d1_v_r <= c_v;
      d2_v_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        d1_p_r[a][c] <= $signed(c_ax[a][c]) * $signed(c_pos[c]);
      end
      d2_s_r[a] <= DSW'(d1_p_r[a][0]) + DSW'(d1_p_r[a][1]) + DSW'(d1_p_r[a][2]) + HALF;
    end
    d1_ax_r  <= c_ax;
    d1_deg_r <= c_deg | c_side[0];
    d2_ax_r  <= d1_ax_r;
    d2_deg_r <= d1_deg_r;
  end

  always_comb begin
    logic signed [DRW-1:0] sh;
    logic signed [DRW:0]   tn;
    for (int a = 0; a < 3; a++) begin
      sh = $signed(d2_s_r[a][DSW-1:FRAC_BITS]);
      tn = (DRW+1)'(0) - (DRW+1)'(sh);
      if (tn > T_MAX) begin
        t_nxt[a] = T_MAX[W-1:0];
      end else if (tn < T_MIN) begin
        t_nxt[a] = T_MIN[W-1:0];
      end else begin
        t_nxt[a] = tn[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      row_r <= '0;
    end else if (d2_v_r) begin
      ov_r  <= 1'b1;
      row_r <= '0;
    end else if (ov_r) begin
      if (row_r == ROW_LAST) begin
        ov_r <= 1'b0;
      end else begin
        row_r <= row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d2_v_r) begin
      ax_r  <= d2_ax_r;
      deg_r <= d2_deg_r;
      for (int a = 0; a < 3; a++) tr_r[a] <= t_nxt[a];
    end
  end

  always_comb begin
    out_data.row_index  = row_r;
    out_data.degenerate = deg_r;
    out_data.last_row   = row_r == ROW_LAST;
    case (row_r)
      ROW_LAST: begin
        out_data.elem_0 = tr_r[0];
        out_data.elem_1 = tr_r[1];
        out_data.elem_2 = tr_r[2];
        out_data.elem_3 = ONE_Q;
      end
      default: begin
        out_data.elem_0 = W'($signed(ax_r[0][row_r]));
        out_data.elem_1 = W'($signed(ax_r[1][row_r]));
        out_data.elem_2 = W'($signed(ax_r[2][row_r]));
        out_data.elem_3 = '0;
      end
    endcase
  end

  assign out_valid = ov_r;

endmodule

@@ test/lookat_view_matrix_chk.sv @@
`timescale 1ns / 100ps
module lookat_view_matrix_chk
  import lvm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  lvm_in_t  in_data,
  input  logic     out_valid,
  input  lvm_out_t out_data,
  output int       n_errors,
  output int       n_pending
);

  localparam longint W_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 1;
  localparam longint W_MIN = -W_MAX - 1;
  localparam longint BIG   = 64'sd1 <<< 62;

  lvm_out_t rows_q[$];

  function automatic longint clamp_word(longint v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // returns 1 for a zero vector
  function automatic bit unit_vec(input longint v[3], output longint o[3]);
    longint unsigned m[3], mx, len, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return 1;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
      o[i] = clamp_word(v[i] < 0 ? -longint'(q) : longint'(q));
    end
    return 0;
  endfunction

  function automatic longint dot_rounded(longint a[3], longint b[3]);
    logic signed [191:0] acc, sh;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += 192'(a[i]) * 192'(b[i]);
    acc += 192'sd1 <<< (FRAC_BITS - 1);
    sh = acc >>> FRAC_BITS;
    if (sh > 192'(BIG)) return BIG;
    if (sh < -192'(BIG)) return -BIG;
    return longint'(sh);
  endfunction

  task automatic predict_matrix(lvm_in_t it);
    longint d[3], p[3], f[3], r[3], u[3], t[3], tmp[3], e[4];
    bit deg;
    lvm_out_t row;
    d = '{-longint'(it.dir_x), -longint'(it.dir_y), -longint'(it.dir_z)};
    p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
    deg = unit_vec(d, f);
    tmp = '{f[2], 0, -f[0]};
    deg |= unit_vec(tmp, r);
    tmp[0] = f[1] * r[2] - f[2] * r[1];
    tmp[1] = f[2] * r[0] - f[0] * r[2];
    tmp[2] = f[0] * r[1] - f[1] * r[0];
    deg |= unit_vec(tmp, u);
    t[0] = clamp_word(-dot_rounded(r, p));
    t[1] = clamp_word(-dot_rounded(u, p));
    t[2] = clamp_word(-dot_rounded(f, p));
    for (int i = 0; i < 4; i++) begin
      if (i < 3) e = '{r[i], u[i], f[i], 0};
      else e = '{t[0], t[1], t[2], clamp_word(64'sd1 <<< FRAC_BITS)};
      row.row_index  = 2'(i);
      row.elem_0     = e[0][WORD_BITS-1:0];
      row.elem_1     = e[1][WORD_BITS-1:0];
      row.elem_2     = e[2][WORD_BITS-1:0];
      row.elem_3     = e[3][WORD_BITS-1:0];
      row.degenerate = deg;
      row.last_row   = (i == 3);
      rows_q.push_back(row);
    end
  endtask

  always @(posedge clk) begin
    lvm_out_t exp_row;
    if (!rst_n) n_errors = 0;
    if (rst_n && start && !busy) predict_matrix(in_data);
    if (rst_n && out_valid) begin
      if (rows_q.size() == 0) begin
        $display("%0t: unexpected row %h", $time, out_data);
        n_errors++;
      end else begin
        exp_row = rows_q.pop_front();
        if (exp_row !== out_data) begin
          $display("%0t: row mismatch expected %h actual %h", $time, exp_row, out_data);
          n_errors++;
        end
      end
    end
    n_pending = rows_q.size();
  end

endmodule

@@ test/lookat_view_matrix_tb.sv @@
`timescale 1ns / 100ps
module lookat_view_matrix_tb;
  import lvm_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = 3 * (FRAC_BITS + 40) + 7 + 8;
  localparam int WD_LIMIT  = 20 * LATENCY;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  lvm_in_t  in_data;
  logic     out_valid;
  lvm_out_t out_data;
  int       n_errors;
  int       n_pending;
  int       idle_pct;
  int       quiet_cycles = 0;

  lookat_view_matrix #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data
  );

  lookat_view_matrix_chk #(.FRAC_BITS(FRAC_BITS)) i_chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data, .n_errors, .n_pending
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return 32'(int'($urandom_range(0, 8)) - 4);
      4: return 32'(int'($urandom_range(0, 2 * 65536)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_matrix(lvm_in_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_dir(logic [31:0] x, y, z, px, py, pz);
    lvm_in_t it;
    it = '{x, y, z, px, py, pz};
    send_matrix(it);
  endtask

  initial begin
    lvm_in_t it;
    rst_n        = 0;
    start        = 0;
    in_data      = '0;
    idle_pct     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_dir(0, 0, 32'hffff_0000, 0, 0, 32'h0005_0000);
    send_dir(0, 0, 0, 1, 2, 3);
    send_dir(0, 32'h0001_0000, 0, 5, 5, 5);
    send_dir(0, 32'hffff_0000, 0, 5, 5, 5);
    send_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_dir(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_dir(32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1);
    send_dir(1, 0, 0, 32'hffff_ffff, 0, 0);
    send_dir(0, 1, 1, 0, 0, 0);
    send_dir(32'h0003_0000, 32'h0004_0000, 32'hfff0_0000, 32'h1234_5678, 32'hedcb_a988, 1);
    send_dir(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'hffff_ffff);
    send_dir(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
             32'haaaa_aaaa);
    start <= 1'b0;
    wait (n_pending == 0);
    repeat (LATENCY) @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 87 : (ph == 3) ? 24 : 0;
      for (int n = 0; n < 100; n++) begin
        it = '{pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
        if ($urandom_range(0, 9) == 0) begin
          it.dir_x = 0;
          it.dir_z = 0;
        end
        send_matrix(it);
      end
    end
    start <= 1'b0;
    wait (n_pending == 0);
    repeat (LATENCY) @(posedge clk);
    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
